/* rtl/hia_pkg.sv */
// ============================================================================
// hia_pkg: handle index allocator shared definitions
// Sizes, request and status codes, transaction structs, controller
// states and the first-free-bit search used by the bitmap scan.
// ============================================================================
`default_nettype none

package hia_pkg;

	// table geometry
	localparam int NUM_HANDLES = 1024;
	localparam int WORD_BITS   = 64;
	localparam int TAG_BITS    = 48;
	localparam int NUM_WORDS   = (NUM_HANDLES + WORD_BITS - 1) / WORD_BITS;

	// derived widths
	localparam int IDX_W    = $clog2(NUM_HANDLES);
	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int WORD_W   = $clog2(NUM_WORDS);
	localparam int CNT_W    = $clog2(NUM_WORDS + 1);
	localparam int HANDLE_W = 16;
	localparam int CODE_W   = 2;

	// request codes
	localparam logic [CODE_W-1:0] REQ_ALLOC  = 2'd0;
	localparam logic [CODE_W-1:0] REQ_FREE   = 2'd1;
	localparam logic [CODE_W-1:0] REQ_LOOKUP = 2'd2;

	// status codes
	localparam logic [CODE_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [CODE_W-1:0] STATUS_FAIL    = 2'd1;
	localparam logic [CODE_W-1:0] STATUS_NOSPACE = 2'd2;

	// request transaction
	typedef struct packed {
		logic [CODE_W-1:0]   req_type;
		logic [HANDLE_W-1:0] handle_index;
		logic [TAG_BITS-1:0] obj_tag;
	} hia_req_t;

	// response transaction
	typedef struct packed {
		logic [CODE_W-1:0]   status;
		logic [IDX_W-1:0]    index_out;
		logic [TAG_BITS-1:0] tag_out;
	} hia_rsp_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EVAL,
		S_RESP
	} hia_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic scan_en;
		logic rd_issue;
		logic eval_en;
		logic out_load;
	} hia_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_alloc;
		logic in_read;
		logic scan_done;
		logic out_free;
	} hia_stat_t;

	// lowest set bit of a bitmap word
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/hia_ram.sv */
// ============================================================================
// hia_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module hia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/hia_ctrl.sv */
// ============================================================================
// hia_ctrl: handle index allocator controller
// Sequences one request at a time through scan, read, evaluate and
// response hand-off.
// ============================================================================
`default_nettype none

module hia_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire hia_pkg::hia_stat_t  stat,
	output hia_pkg::hia_cmd_t        cmd
);

	hia_pkg::hia_state_t state_q;
	hia_pkg::hia_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hia_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			hia_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					priority if (stat.in_alloc) begin
						state_d = hia_pkg::S_SCAN;
					end else if (stat.in_read) begin
						state_d = hia_pkg::S_READ;
					end else begin
						state_d = hia_pkg::S_EVAL;
					end
				end
			end
			hia_pkg::S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_done) begin
					state_d = hia_pkg::S_RESP;
				end
			end
			hia_pkg::S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = hia_pkg::S_EVAL;
			end
			hia_pkg::S_EVAL: begin
				cmd.eval_en = 1'b1;
				state_d     = hia_pkg::S_RESP;
			end
			hia_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = hia_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hia_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/hia_dp.sv */
// ============================================================================
// hia_dp: handle index allocator datapath
// Bitmap words, next-fit pointer, word scan, object table and the
// response register.
// ============================================================================
`default_nettype none

module hia_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hia_pkg::hia_req_t  req,
	input  wire hia_pkg::hia_cmd_t  cmd,
	output hia_pkg::hia_stat_t      stat,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output hia_pkg::hia_rsp_t       rsp
);

	// state
	logic [hia_pkg::WORD_BITS-1:0] bitmap_q [hia_pkg::NUM_WORDS];
	logic [hia_pkg::IDX_W-1:0]     ptr_q;
	logic [hia_pkg::CNT_W-1:0]     scan_cnt_q;
	logic                          out_valid_q;

	// request and result holding registers
	logic [hia_pkg::CODE_W-1:0]    req_type_q;
	logic [hia_pkg::IDX_W-1:0]     idx_q;
	logic                          oob_q;
	logic [hia_pkg::TAG_BITS-1:0]  tag_q;
	hia_pkg::hia_rsp_t             res_q;
	hia_pkg::hia_rsp_t             out_q;

	// scan and lookup logic
	logic [hia_pkg::WORD_W-1:0]    scan_word;
	logic [hia_pkg::WORD_W-1:0]    word_addr;
	logic [hia_pkg::WORD_BITS-1:0] cur_word;
	logic [hia_pkg::WORD_BITS-1:0] hi_mask;
	logic [hia_pkg::WORD_BITS-1:0] scan_mask;
	logic [hia_pkg::WORD_BITS-1:0] free_bits;
	logic                          scan_first;
	logic                          scan_last;
	logic                          scan_found;
	logic [hia_pkg::IDX_W-1:0]     scan_pos;
	logic [hia_pkg::TAG_BITS-1:0]  ram_rdata;
	logic [hia_pkg::TAG_BITS-1:0]  tag_live;
	logic                          bit_set;
	logic                          tag_nz;
	logic                          alloc_wr;
	logic                          free_ok;

	// request decode for the controller
	assign stat.in_alloc = (req.req_type == hia_pkg::REQ_ALLOC);
	assign stat.in_read  = ((req.req_type == hia_pkg::REQ_FREE) ||
		(req.req_type == hia_pkg::REQ_LOOKUP)) &&
		(req.handle_index[hia_pkg::HANDLE_W-1:hia_pkg::IDX_W] == '0);

	// one bitmap word a cycle, from the pointer's word around to it again
	assign scan_word  = ptr_q[hia_pkg::IDX_W-1:hia_pkg::BIT_W] +
		scan_cnt_q[hia_pkg::WORD_W-1:0];
	assign word_addr  = cmd.scan_en ? scan_word : idx_q[hia_pkg::IDX_W-1:hia_pkg::BIT_W];
	assign cur_word   = bitmap_q[word_addr];
	assign scan_first = (scan_cnt_q == '0);
	assign scan_last  = (scan_cnt_q == hia_pkg::CNT_W'(hia_pkg::NUM_WORDS));
	assign hi_mask    = {hia_pkg::WORD_BITS{1'b1}} << ptr_q[hia_pkg::BIT_W-1:0];

	// first pass covers bits at or above the pointer, wrap pass those below
	always_comb begin
		priority if (scan_first) begin
			scan_mask = hi_mask;
		end else if (scan_last) begin
			scan_mask = ~hi_mask;
		end else begin
			scan_mask = '1;
		end
	end

	assign free_bits      = ~cur_word & scan_mask;
	assign scan_found     = |free_bits;
	assign scan_pos       = {scan_word, hia_pkg::first_set(free_bits)};
	assign stat.scan_done = scan_found || scan_last;
	assign alloc_wr       = cmd.scan_en && scan_found;

	// a clear bit means an empty slot, whatever the table holds
	assign bit_set  = cur_word[idx_q[hia_pkg::BIT_W-1:0]];
	assign tag_live = bit_set ? ram_rdata : '0;
	assign tag_nz   = |tag_live;
	assign free_ok  = cmd.eval_en && !oob_q && (req_type_q == hia_pkg::REQ_FREE) && tag_nz;

	// object table
	hia_ram #(
		.WIDTH (hia_pkg::TAG_BITS),
		.DEPTH (hia_pkg::NUM_HANDLES)
	) u_table (
		.clk   (clk),
		.we    (alloc_wr),
		.waddr (scan_pos),
		.wdata (tag_q),
		.re    (cmd.rd_issue),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// control state: bitmap, pointer, scan count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < hia_pkg::NUM_WORDS; w++) begin
				bitmap_q[w] <= '0;
			end
			ptr_q       <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_en) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (alloc_wr) begin
				bitmap_q[word_addr][scan_pos[hia_pkg::BIT_W-1:0]] <= 1'b1;
				ptr_q <= scan_pos + 1'b1;
			end
			if (free_ok) begin
				bitmap_q[word_addr][idx_q[hia_pkg::BIT_W-1:0]] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result formation
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req.req_type;
			idx_q      <= req.handle_index[hia_pkg::IDX_W-1:0];
			oob_q      <= (req.handle_index[hia_pkg::HANDLE_W-1:hia_pkg::IDX_W] != '0);
			tag_q      <= req.obj_tag;
		end
		if (cmd.scan_en) begin
			if (scan_found) begin
				res_q.status    <= hia_pkg::STATUS_OK;
				res_q.index_out <= scan_pos;
				res_q.tag_out   <= '0;
			end else begin
				res_q.status    <= hia_pkg::STATUS_NOSPACE;
				res_q.index_out <= '0;
				res_q.tag_out   <= '0;
			end
		end
		if (cmd.eval_en) begin
			res_q.index_out <= '0;
			if (!oob_q && tag_nz && (req_type_q == hia_pkg::REQ_FREE)) begin
				res_q.status  <= hia_pkg::STATUS_OK;
				res_q.tag_out <= '0;
			end else if (!oob_q && tag_nz && (req_type_q == hia_pkg::REQ_LOOKUP)) begin
				res_q.status  <= hia_pkg::STATUS_OK;
				res_q.tag_out <= tag_live;
			end else begin
				res_q.status  <= hia_pkg::STATUS_FAIL;
				res_q.tag_out <= '0;
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign stat.out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid     = out_valid_q;
	assign rsp           = out_q;

	// scan never runs past the wrap pass
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_en |-> (scan_cnt_q <= hia_pkg::CNT_W'(hia_pkg::NUM_WORDS)))
		else $error("bitmap scan ran past the wrap pass");

	// pointer moves just past a granted index
	a_ptr_next: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_wr |=> (ptr_q == hia_pkg::IDX_W'($past(scan_pos) + 1'b1)))
		else $error("next-fit pointer not advanced past grant");

	// a stalled response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(rsp_valid && rsp_stall))
		else $error("response overwritten while stalled");

	// a granted slot was free when the scan picked it
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_wr |-> !cur_word[scan_pos[hia_pkg::BIT_W-1:0]])
		else $error("scan granted a used slot");

endmodule

`default_nettype wire

/* rtl/handle_index_allocator_core.sv */
// ============================================================================
// handle_index_allocator_core: bitmap next-fit handle allocator
// Allocates, frees and looks up handles backed by an object tag table.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req) carries allocate, free and lookup
//   transactions; rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one
//   response transaction per request, in order.
//   One request is worked on at a time; req_stall is high while it is busy.
//   Allocate scans the used bitmap one word per cycle starting at the
//   next-fit pointer's word and wrapping once back to that word.
//   Free and lookup read the tag table through its registered read port;
//   an out-of-range index or an unknown code skips the read.
//   The next request is taken in the cycle after the response is loaded,
//   so no new request starts before the last one's response is loaded.
//   The response sits in an output register; while rsp_stall is high the
//   block still takes and works one more request, then holds it until the
//   output register drains.
//   Reset clears the bitmap and the pointer at once; the bitmap also marks
//   which table entries hold data, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module handle_index_allocator_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire hia_pkg::hia_req_t  req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output hia_pkg::hia_rsp_t       rsp
);

	hia_pkg::hia_cmd_t  cmd;
	hia_pkg::hia_stat_t stat;

	// request sequencer
	hia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// bitmap, table and response datapath
	hia_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
